// ===== hdl/selective_repeat_send_window_assert.svh =====
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SRSW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("send window check failed");

// next-cycle implication, checked outside reset
`define SRSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("send window check failed");

`endif

// ===== hdl/srsw_pkg.sv =====
package srsw_pkg;

	localparam int SEQ_BITS = 32;
	localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

	typedef enum logic [1:0] {
		REQ_STORE,
		REQ_GET,
		REQ_REMOVE,
		REQ_REMOVE_TO
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_OUTSIDE,
		STAT_OCCUPIED,
		STAT_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_SLIDE,
		S_FIN,
		S_SCAN,
		S_EMIT
	} fsm_t;

	typedef struct packed {
		status_t status;
		logic    handle_valid;
		logic    has_room;
		logic    is_empty;
		logic    last;
	} res_flags_t;

endpackage

// ===== hdl/srsw_ram.sv =====
module srsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/srsw_obuf.sv =====
module srsw_obuf import srsw_pkg::*; #(
	parameter int HANDLE_BITS = 16,
	localparam int OUT_W = ((SEQ_BITS + HANDLE_BITS + 5 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  res_flags_t             flags,
	input  logic [HANDLE_BITS-1:0] handle,
	input  logic [SEQ_BITS-1:0]    base,
	output logic                   ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_W-1:0]       m_tdata,
	output logic                   m_tlast
);

	logic             vld_q;
	logic [OUT_W-1:0] data_q;
	logic             last_q;

	assign ready    = !vld_q || m_tready;
	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= OUT_W'({base, flags.is_empty, flags.has_room, flags.handle_valid,
				handle, flags.status});
			last_q <= flags.last;
		end
	end

endmodule

// ===== hdl/selective_repeat_send_window.sv =====
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tuser: req_type; s_tdata: seq_num, buf_handle
// m_*      out  m_tvalid/m_tready   m_tdata: status..base_seq; m_tlast: last_of_run
//
// Store and get step through accept, slot lookup and result.
// Remove one, when the slot is held, adds a slide of the base over empty slots (at most WINDOW).
// Remove-to walks one slot a cycle (at most WINDOW slots), slides, then scans the freed
// slots, reading each freed handle from the handle RAM and stepping over the other slots.
// Reset clears base, highest and the slot valid bits at once; handle RAM is not cleared.
// A result waits in the output register while the next item is accepted.
`include "selective_repeat_send_window_assert.svh"

module selective_repeat_send_window import srsw_pkg::*; #(
	parameter int WINDOW = 16,
	parameter int HANDLE_BITS = 16,
	localparam int IN_W = ((SEQ_BITS + HANDLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((SEQ_BITS + HANDLE_BITS + 5 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // seq_num, buf_handle
	input  logic [1:0]       s_tuser,  // req_type
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // status, out_handle, handle_valid, has_room,
	                                   // is_empty, base_seq
	output logic             m_tlast   // last_of_run
);

	localparam int SW = $clog2(WINDOW);
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [SW:0]   WIN_C     = (SW + 1)'(WINDOW);
	localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);
	localparam logic [CW-1:0] CNT_WIN   = CW'(WINDOW);

	fsm_t st_q, st_d;

	req_t                   req_q;
	logic [SEQ_BITS-1:0]    seq_q;
	logic [HANDLE_BITS-1:0] hin_q;

	logic [SEQ_BITS-1:0] base_q, high_q;
	logic [SW-1:0]       bslot_q;
	logic [WINDOW-1:0]   valid_q, free_q;
	logic [CW-1:0]       cnt_q, nfreed_q, nemit_q;
	logic [SW-1:0]       wslot_q, scan0_q;
	status_t             fstat_q;
	logic                fhv_q;

	// slot lookup for the addressed sequence
	logic [SEQ_BITS-1:0] diff;
	logic                in_win;
	logic [SW:0]         ssum;
	logic [SW-1:0]       s_slot;
	logic                s_valid;

	// walk / slide
	logic [SEQ_BITS:0]   walk_p, high1;
	logic                walk_stop, slide_stop;
	logic [SEQ_BITS-1:0] target, tdiff;
	logic                tgt_up;
	logic [SW:0]         tsum;
	logic [SW-1:0]       tslot, wnext, bnext;
	logic                room, empty, last_emit;

	// RAM and output stage
	logic                   ram_we, ram_re;
	logic [SW-1:0]          ram_raddr;
	logic [HANDLE_BITS-1:0] ram_rdata;
	logic                   ob_load, ob_ready;
	res_flags_t             ob_flags;
	logic [HANDLE_BITS-1:0] ob_handle;

	assign s_tready = (st_q == S_IDLE);

	assign diff    = seq_q - base_q;
	assign in_win  = (seq_q >= base_q) && (diff < SEQ_BITS'(WINDOW));
	assign ssum    = {1'b0, bslot_q} + {1'b0, diff[SW-1:0]};
	assign s_slot  = (ssum >= WIN_C) ? SW'(ssum - WIN_C) : ssum[SW-1:0];
	assign s_valid = valid_q[s_slot];

	assign high1     = {1'b0, high_q} + (SEQ_BITS + 1)'(1);
	assign walk_p    = {1'b0, base_q} + (SEQ_BITS + 1)'(cnt_q);
	assign walk_stop = (walk_p >= {1'b0, seq_q}) || (walk_p > {1'b0, high_q}) ||
		(cnt_q == CNT_WIN);

	// cumulative ack target, clamped to highest + 1 (never past the top of the space)
	assign target = ({1'b0, seq_q} <= high1) ? seq_q : high1[SEQ_BITS-1:0];
	assign tgt_up = target > base_q;
	assign tdiff  = target - base_q;
	assign tsum   = {1'b0, bslot_q} + tdiff[SW:0];
	assign tslot  = (tsum >= WIN_C) ? SW'(tsum - WIN_C) : tsum[SW-1:0];

	assign wnext = (wslot_q == SLOT_LAST) ? '0 : wslot_q + 1'b1;
	assign bnext = (bslot_q == SLOT_LAST) ? '0 : bslot_q + 1'b1;

	assign slide_stop = (base_q > high_q) || (base_q == SEQ_MAX) || valid_q[bslot_q];

	assign room  = ({1'b0, base_q} + (SEQ_BITS + 1)'(WINDOW)) > high1;
	assign empty = (({1'b0, base_q} == high1) || (base_q == '0 && high_q == '0)) &&
		!valid_q[bslot_q];
	assign last_emit = (CW'(nemit_q + 1'b1) == nfreed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = s_slot;
		ob_load   = 1'b0;
		ob_flags  = '{status: STAT_OK, handle_valid: 1'b0, has_room: room,
			is_empty: empty, last: 1'b1};
		ob_handle = '0;
		case (st_q)
			S_IDLE: begin
				if (s_tvalid) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (req_q)
					REQ_STORE: begin
						ram_we = in_win && !s_valid;
						st_d   = S_FIN;
					end
					REQ_GET: begin
						ram_re = in_win && s_valid;
						st_d   = S_FIN;
					end
					REQ_REMOVE: begin
						ram_re = in_win && s_valid;
						st_d   = (in_win && s_valid) ? S_SLIDE : S_FIN;
					end
					REQ_REMOVE_TO: begin
						st_d = S_WALK;
					end
					default: begin
						st_d = S_FIN;
					end
				endcase
			end
			S_WALK: begin
				if (walk_stop) begin
					st_d = S_SLIDE;
				end
			end
			S_SLIDE: begin
				if (slide_stop) begin
					st_d = (req_q == REQ_REMOVE_TO && nfreed_q != '0) ? S_SCAN : S_FIN;
				end
			end
			S_FIN: begin
				ob_load               = ob_ready;
				ob_flags.status       = fstat_q;
				ob_flags.handle_valid = fhv_q;
				ob_handle             = fhv_q ? ram_rdata : '0;
				if (ob_ready) begin
					st_d = S_IDLE;
				end
			end
			S_SCAN: begin
				ram_raddr = wslot_q;
				if (free_q[wslot_q]) begin
					ram_re = 1'b1;
					st_d   = S_EMIT;
				end
			end
			S_EMIT: begin
				ob_load               = ob_ready;
				ob_flags.handle_valid = 1'b1;
				ob_flags.last         = last_emit;
				ob_handle             = ram_rdata;
				if (ob_ready) begin
					st_d = last_emit ? S_IDLE : S_SCAN;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_tvalid) begin
			req_q <= req_t'(s_tuser);
			seq_q <= s_tdata[SEQ_BITS-1:0];
			hin_q <= s_tdata[SEQ_BITS +: HANDLE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			high_q   <= '0;
			bslot_q  <= '0;
			valid_q  <= '0;
			free_q   <= '0;
			cnt_q    <= '0;
			nfreed_q <= '0;
			nemit_q  <= '0;
			wslot_q  <= '0;
			scan0_q  <= '0;
			fstat_q  <= STAT_OK;
			fhv_q    <= 1'b0;
		end else begin
			case (st_q)
				S_EXEC: begin
					case (req_q)
						REQ_STORE: begin
							fhv_q <= 1'b0;
							if (!in_win) begin
								fstat_q <= STAT_OUTSIDE;
							end else if (s_valid) begin
								fstat_q <= STAT_OCCUPIED;
							end else begin
								fstat_q         <= STAT_OK;
								valid_q[s_slot] <= 1'b1;
								if (seq_q > high_q) begin
									high_q <= seq_q;
								end
							end
						end
						REQ_GET, REQ_REMOVE: begin
							fhv_q   <= in_win && s_valid;
							fstat_q <= !in_win ? STAT_OUTSIDE :
								(!s_valid ? STAT_EMPTY : STAT_OK);
							if (req_q == REQ_REMOVE && in_win && s_valid) begin
								valid_q[s_slot] <= 1'b0;
							end
						end
						default: begin
							fstat_q  <= STAT_OK;
							fhv_q    <= 1'b0;
							cnt_q    <= '0;
							nfreed_q <= '0;
							wslot_q  <= bslot_q;
							scan0_q  <= bslot_q;
						end
					endcase
				end
				S_WALK: begin
					if (walk_stop) begin
						if (tgt_up) begin
							base_q  <= target;
							bslot_q <= tslot;
						end
					end else begin
						if (valid_q[wslot_q]) begin
							valid_q[wslot_q] <= 1'b0;
							free_q[wslot_q]  <= 1'b1;
							nfreed_q         <= nfreed_q + 1'b1;
						end
						cnt_q   <= cnt_q + 1'b1;
						wslot_q <= wnext;
					end
				end
				S_SLIDE: begin
					if (slide_stop) begin
						wslot_q <= scan0_q;
						nemit_q <= '0;
					end else begin
						base_q  <= base_q + 1'b1;
						bslot_q <= bnext;
					end
				end
				S_SCAN: begin
					if (!free_q[wslot_q]) begin
						wslot_q <= wnext;
					end
				end
				S_EMIT: begin
					if (ob_ready) begin
						free_q[wslot_q] <= 1'b0;
						wslot_q         <= wnext;
						nemit_q         <= nemit_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	srsw_ram #(
		.WIDTH(HANDLE_BITS),
		.DEPTH(WINDOW)
	) u_handles (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s_slot),
		.wdata(hin_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	srsw_obuf #(
		.HANDLE_BITS(HANDLE_BITS)
	) u_obuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (ob_load),
		.flags   (ob_flags),
		.handle  (ob_handle),
		.base    (base_q),
		.ready   (ob_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	`SRSW_ASSERT_NEXT(a_base_mono, 1'b1, base_q >= $past(base_q))
	`SRSW_ASSERT_NOW(a_base_bound, 1'b1, {1'b0, base_q} <= high1)
	`SRSW_ASSERT_NOW(a_high_in_win, 1'b1, {1'b0, high_q} < ({1'b0, base_q} + (SEQ_BITS + 1)'(WINDOW)))
	`SRSW_ASSERT_NOW(a_emit_count, st_q == S_EMIT, nemit_q < nfreed_q)

endmodule
